@@ design/vga_pkg.sv @@
// shared constants and action codes for the vector geometry alu
`default_nettype none
package vga_pkg;
  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int ACT_BITS      = 4;
  localparam int TOL_BITS      = 16;
  localparam int LANES         = 4;

  localparam logic [TOL_BITS-1:0] TOL_RESET = 16'd7;

  localparam logic [ACT_BITS-1:0] ACT_ADD     = 4'd0;
  localparam logic [ACT_BITS-1:0] ACT_SUB     = 4'd1;
  localparam logic [ACT_BITS-1:0] ACT_NEG     = 4'd2;
  localparam logic [ACT_BITS-1:0] ACT_SCALE   = 4'd3;
  localparam logic [ACT_BITS-1:0] ACT_MUL     = 4'd4;
  localparam logic [ACT_BITS-1:0] ACT_DIVS    = 4'd5;
  localparam logic [ACT_BITS-1:0] ACT_DIV     = 4'd6;
  localparam logic [ACT_BITS-1:0] ACT_DOT     = 4'd7;
  localparam logic [ACT_BITS-1:0] ACT_CROSS   = 4'd8;
  localparam logic [ACT_BITS-1:0] ACT_MAG     = 4'd9;
  localparam logic [ACT_BITS-1:0] ACT_NORM    = 4'd10;
  localparam logic [ACT_BITS-1:0] ACT_REFLECT = 4'd11;
  localparam logic [ACT_BITS-1:0] ACT_EQ      = 4'd12;
  localparam logic [ACT_BITS-1:0] ACT_ISPOINT = 4'd13;
endpackage
`default_nettype wire

@@ design/vga_in_if.sv @@
// input channel: two tuples, a scalar and an action
`default_nettype none
interface vga_in_if #(
  parameter int WORD_BITS = vga_pkg::WORD_BITS_DEF
);
  import vga_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [ACT_BITS-1:0]         action;
  logic signed [WORD_BITS-1:0] a_x;
  logic signed [WORD_BITS-1:0] a_y;
  logic signed [WORD_BITS-1:0] a_z;
  logic signed [WORD_BITS-1:0] a_w;
  logic signed [WORD_BITS-1:0] b_x;
  logic signed [WORD_BITS-1:0] b_y;
  logic signed [WORD_BITS-1:0] b_z;
  logic signed [WORD_BITS-1:0] b_w;
  logic signed [WORD_BITS-1:0] scalar_in;

  modport source (
    output valid, action, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scalar_in,
    input  ready
  );
  modport sink (
    input  valid, action, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scalar_in,
    output ready
  );
endinterface
`default_nettype wire

@@ design/vga_out_if.sv @@
// result channel: tuple, scalar, flag and divide error
`default_nettype none
interface vga_out_if #(
  parameter int WORD_BITS = vga_pkg::WORD_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] r_x;
  logic signed [WORD_BITS-1:0] r_y;
  logic signed [WORD_BITS-1:0] r_z;
  logic signed [WORD_BITS-1:0] r_w;
  logic signed [WORD_BITS-1:0] r_scalar;
  logic                        flag;
  logic                        div_error;

  modport source (
    output valid, r_x, r_y, r_z, r_w, r_scalar, flag, div_error,
    input  ready
  );
  modport sink (
    input  valid, r_x, r_y, r_z, r_w, r_scalar, flag, div_error,
    output ready
  );
endinterface
`default_nettype wire

@@ design/vga_lane.sv @@
// one component lane: products, elementwise ops, cross term and reflect step
`default_nettype none
module vga_lane #(
  parameter int WORD_BITS = vga_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = vga_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic [vga_pkg::ACT_BITS-1:0]    act_s0,
  input  logic [vga_pkg::ACT_BITS-1:0]    act_s1,
  input  logic [vga_pkg::ACT_BITS-1:0]    act_s3,
  input  logic [vga_pkg::TOL_BITS-1:0]    tol,
  input  logic signed [WORD_BITS-1:0]     a,
  input  logic signed [WORD_BITS-1:0]     b,
  input  logic signed [WORD_BITS-1:0]     s,
  input  logic signed [WORD_BITS-1:0]     xa_j,
  input  logic signed [WORD_BITS-1:0]     xb_k,
  input  logic signed [WORD_BITS-1:0]     xa_k,
  input  logic signed [WORD_BITS-1:0]     xb_j,
  input  logic signed [WORD_BITS-1:0]     dot_s2,
  output logic signed [2*WORD_BITS-1:0]   prod_s1,
  output logic                            eq_s1,
  output logic signed [WORD_BITS-1:0]     res_s4,
  output logic signed [WORD_BITS-1:0]     num_s4,
  output logic signed [WORD_BITS-1:0]     den_s4
);
  import vga_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * W;
  localparam int SW = 2 * W + 2;
  localparam logic signed [SW-1:0] MAX_X = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] MIN_X = ~MAX_X;

  function automatic logic signed [W-1:0] sat_w(input logic signed [SW-1:0] v);
    if (v > MAX_X) return {1'b0, {(W-1){1'b1}}};
    else if (v < MIN_X) return {1'b1, {(W-1){1'b0}}};
    else return v[W-1:0];
  endfunction

  // stage 0 combinational
  logic signed [W-1:0]  opnd;
  logic signed [W-1:0]  elem;
  logic signed [W-1:0]  den0;
  logic signed [SW-1:0] diff;
  logic [SW-1:0]        absd;
  logic                 eq0;

  always_comb begin
    if (act_s0 == ACT_SCALE) opnd = s;
    else if (act_s0 == ACT_MAG || act_s0 == ACT_NORM) opnd = a;
    else opnd = b;
    case (act_s0)
      ACT_ADD: elem = sat_w(SW'(a) + SW'(b));
      ACT_SUB: elem = sat_w(SW'(a) - SW'(b));
      ACT_NEG: elem = sat_w(-SW'(a));
      default: elem = '0;
    endcase
    den0 = (act_s0 == ACT_DIVS) ? s : b;
    diff = SW'(a) - SW'(b);
    absd = (diff < 0) ? $unsigned(-diff) : $unsigned(diff);
    eq0  = absd < SW'(tol);
  end

  logic signed [PW-1:0] prod_r, cp0_r, cp1_r;
  logic signed [W-1:0]  elem1_r, a1_r, b1_r, den1_r;
  logic                 eq1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= PW'(a) * PW'(opnd);
      cp0_r   <= PW'(xa_j) * PW'(xb_k);
      cp1_r   <= PW'(xa_k) * PW'(xb_j);
      elem1_r <= elem;
      eq1_r   <= eq0;
      a1_r    <= a;
      b1_r    <= b;
      den1_r  <= den0;
    end
  end

  assign prod_s1 = prod_r;
  assign eq_s1   = eq1_r;

  // stage 1: floor shift of products and selection
  logic signed [W-1:0] res1;

  always_comb begin
    case (act_s1)
      ACT_ADD, ACT_SUB, ACT_NEG: res1 = elem1_r;
      ACT_SCALE, ACT_MUL:        res1 = sat_w(SW'(prod_r) >>> F);
      ACT_CROSS:                 res1 = sat_w((SW'(cp0_r) - SW'(cp1_r)) >>> F);
      default:                   res1 = '0;
    endcase
  end

  logic signed [W-1:0] res2_r, a2_r, b2x_r, den2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      res2_r <= res1;
      a2_r   <= a1_r;
      b2x_r  <= sat_w(SW'(b1_r) + SW'(b1_r));
      den2_r <= den1_r;
    end
  end

  // stage 2: reflect product against the merged dot
  logic signed [PW-1:0] mp_r;
  logic signed [W-1:0]  res3_r, a3_r, den3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      mp_r   <= PW'(b2x_r) * PW'(dot_s2);
      res3_r <= res2_r;
      a3_r   <= a2_r;
      den3_r <= den2_r;
    end
  end

  // stage 3: reflect subtract
  logic signed [W-1:0] refl_m;
  logic signed [W-1:0] refl;
  logic signed [W-1:0] res4_r, a4_r, den4_r;

  assign refl_m = sat_w(SW'(mp_r) >>> F);
  assign refl   = sat_w(SW'(a3_r) - SW'(refl_m));

  always_ff @(posedge clk) begin
    if (en) begin
      res4_r <= (act_s3 == ACT_REFLECT) ? refl : res3_r;
      a4_r   <= a3_r;
      den4_r <= den3_r;
    end
  end

  assign res_s4 = res4_r;
  assign num_s4 = a4_r;
  assign den_s4 = den4_r;
endmodule
`default_nettype wire

@@ design/vga_sqrt.sv @@
// pipelined integer square root, one result bit per stage
`default_nettype none
module vga_sqrt #(
  parameter int WORD_BITS = vga_pkg::WORD_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [2*WORD_BITS-1:0]   rad,
  output logic [WORD_BITS-1:0]     root
);
  localparam int W  = WORD_BITS;
  localparam int RW = W + 2;
  localparam int XW = W + 4;

  logic [RW-1:0]  rem_q  [W];
  logic [W-1:0]   root_q [W];
  logic [2*W-1:0] rad_q  [W];

  for (genvar k = 0; k < W; k++) begin : g_st
    logic [RW-1:0]  rem_p;
    logic [W-1:0]   root_p;
    logic [2*W-1:0] rad_p;
    logic [XW-1:0]  rs;
    logic [XW-1:0]  trial;
    logic [RW-1:0]  rem_r;
    logic [W-1:0]   root_r;
    logic [2*W-1:0] rad_r;

    if (k == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = rad;
    end else begin : g_next
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign rad_p  = rad_q[k-1];
    end

    // bring down the next two radicand bits, try root*4+1
    assign rs    = {rem_p, rad_p[2*W-1 -: 2]};
    assign trial = {2'b00, root_p, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        if (rs >= trial) begin
          rem_r  <= RW'(rs - trial);
          root_r <= {root_p[W-2:0], 1'b1};
        end else begin
          rem_r  <= RW'(rs);
          root_r <= {root_p[W-2:0], 1'b0};
        end
        rad_r <= rad_p << 2;
      end
    end

    assign rem_q[k]  = rem_r;
    assign root_q[k] = root_r;
    assign rad_q[k]  = rad_r;
  end

  assign root = root_q[W-1];
endmodule
`default_nettype wire

@@ design/vga_div.sv @@
// pipelined signed fixed point divider, one quotient bit per stage, saturating
`default_nettype none
module vga_div #(
  parameter int WORD_BITS = vga_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = vga_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [WORD_BITS-1:0] num,
  input  logic signed [WORD_BITS-1:0] den,
  output logic signed [WORD_BITS-1:0] quo,
  output logic                        dz
);
  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int QB = W + F;
  localparam logic [QB-1:0] QMAX = {{(F+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [QB-1:0] QLIM = {{F{1'b0}}, 1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0]  WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  WMIN = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    logic neg;
    logic zero;
    logic npos;
    logic nneg;
  } dflg_t;

  logic [W-1:0] nmag, dmag;
  dflg_t        flg0;

  assign nmag      = num[W-1] ? W'(-num) : num;
  assign dmag      = den[W-1] ? W'(-den) : den;
  assign flg0.neg  = num[W-1] ^ den[W-1];
  assign flg0.zero = (den == '0);
  assign flg0.npos = !num[W-1] && (num != '0);
  assign flg0.nneg = num[W-1];

  logic [W-1:0]  rem_q [QB];
  logic [QB-1:0] quo_q [QB];
  logic [QB-1:0] dvd_q [QB];
  logic [W-1:0]  dm_q  [QB];
  dflg_t         flg_q [QB];

  for (genvar k = 0; k < QB; k++) begin : g_st
    logic [W-1:0]  rem_p, dm_p;
    logic [QB-1:0] quo_p, dvd_p;
    dflg_t         flg_p;
    logic [W:0]    rs;
    logic          ge;
    logic [W-1:0]  rem_r, dm_r;
    logic [QB-1:0] quo_r, dvd_r;
    dflg_t         flg_r;

    if (k == 0) begin : g_first
      assign rem_p = '0;
      assign quo_p = '0;
      assign dvd_p = {nmag, {F{1'b0}}};
      assign dm_p  = dmag;
      assign flg_p = flg0;
    end else begin : g_next
      assign rem_p = rem_q[k-1];
      assign quo_p = quo_q[k-1];
      assign dvd_p = dvd_q[k-1];
      assign dm_p  = dm_q[k-1];
      assign flg_p = flg_q[k-1];
    end

    assign rs = {rem_p, dvd_p[QB-1]};
    assign ge = rs >= {1'b0, dm_p};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r <= ge ? W'(rs - {1'b0, dm_p}) : W'(rs);
        quo_r <= {quo_p[QB-2:0], ge};
        dvd_r <= dvd_p << 1;
        dm_r  <= dm_p;
        flg_r <= flg_p;
      end
    end

    assign rem_q[k] = rem_r;
    assign quo_q[k] = quo_r;
    assign dvd_q[k] = dvd_r;
    assign dm_q[k]  = dm_r;
    assign flg_q[k] = flg_r;
  end

  logic [QB-1:0] qm;
  dflg_t         fl;

  assign qm = quo_q[QB-1];
  assign fl = flg_q[QB-1];

  always_comb begin
    if (fl.zero) begin
      if (fl.npos) quo = WMAX;
      else if (fl.nneg) quo = WMIN;
      else quo = '0;
    end else if (!fl.neg) begin
      quo = (qm > QMAX) ? WMAX : qm[W-1:0];
    end else begin
      quo = (qm > QLIM) ? WMIN : (~qm[W-1:0] + {{(W-1){1'b0}}, 1'b1});
    end
  end

  assign dz = fl.zero;
endmodule
`default_nettype wire

@@ design/vec4_geometry_alu.sv @@
// top level: four lanes, dot/square merge, square root and divider pipelines
// format: Q16.16 at the default WORD_BITS and FRAC_BITS
// throughput: one item per cycle; the whole pipeline advances whenever the output
// register is empty or being taken, and the root and divider resolve one bit per stage
// reset: rst_n synchronous active low clears all stage valid bits, tolerance returns to 7
`default_nettype none
module vec4_geometry_alu #(
  parameter int WORD_BITS = vga_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = vga_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [vga_pkg::TOL_BITS-1:0]  cfg_wdata,
  vga_in_if.sink                        in_ch,
  vga_out_if.source                     out_ch
);
  import vga_pkg::*;

  localparam int W     = WORD_BITS;
  localparam int F     = FRAC_BITS;
  localparam int PW    = 2 * W;
  localparam int SW    = 2 * W + 2;
  localparam int SQ_ST = W;
  localparam int DV_ST = W + F;
  localparam int LAT   = 5 + SQ_ST + DV_ST;
  localparam logic signed [SW-1:0] MAX_X = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] MIN_X = ~MAX_X;
  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};

  function automatic logic signed [W-1:0] sat_w(input logic signed [SW-1:0] v);
    if (v > MAX_X) return {1'b0, {(W-1){1'b1}}};
    else if (v < MIN_X) return {1'b1, {(W-1){1'b0}}};
    else return v[W-1:0];
  endfunction

  typedef struct packed {
    logic [ACT_BITS-1:0]         act;
    logic [W-1:0]                dot;
    logic                        flag;
    logic [LANES-1:0][W-1:0]     res;
    logic [LANES-1:0][W-1:0]     num;
    logic [LANES-1:0][W-1:0]     den;
  } side_t;

  typedef struct packed {
    logic [ACT_BITS-1:0]         act;
    logic [W-1:0]                sc;
    logic                        flag;
    logic [LANES-1:0][W-1:0]     res;
  } side2_t;

  // handshake and stage valids
  logic [LAT-1:0] vld_r;
  logic           en;
  logic           in_xfer;

  assign en           = !vld_r[LAT-1] || out_ch.ready;
  assign in_ch.ready  = en;
  assign in_xfer      = in_ch.valid && en;
  assign out_ch.valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_xfer};
    end
  end

  logic [TOL_BITS-1:0] tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  // lanes
  logic signed [W-1:0]  a_v [LANES];
  logic signed [W-1:0]  b_v [LANES];
  logic signed [PW-1:0] prod_v [LANES];
  logic [LANES-1:0]     eq_v;
  logic signed [W-1:0]  res_v [LANES];
  logic signed [W-1:0]  num_v [LANES];
  logic signed [W-1:0]  den_v [LANES];

  assign a_v[0] = in_ch.a_x;
  assign a_v[1] = in_ch.a_y;
  assign a_v[2] = in_ch.a_z;
  assign a_v[3] = in_ch.a_w;
  assign b_v[0] = in_ch.b_x;
  assign b_v[1] = in_ch.b_y;
  assign b_v[2] = in_ch.b_z;
  assign b_v[3] = in_ch.b_w;

  logic [ACT_BITS-1:0] act1_r, act2_r, act3_r, act4_r;
  logic signed [W-1:0] dot2_r, dot3_r, dot4_r;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    logic signed [W-1:0] xa_j, xb_k, xa_k, xb_j;

    // cross component i = a_j*b_k - a_k*b_j; w lane gets zero
    if (i < 3) begin : g_xyz
      localparam int J = (i + 1) % 3;
      localparam int K = (i + 2) % 3;
      assign xa_j = a_v[J];
      assign xb_k = b_v[K];
      assign xa_k = a_v[K];
      assign xb_j = b_v[J];
    end else begin : g_w
      assign xa_j = '0;
      assign xb_k = '0;
      assign xa_k = '0;
      assign xb_j = '0;
    end

    vga_lane #(
      .WORD_BITS (W),
      .FRAC_BITS (F)
    ) u_lane (
      .clk     (clk),
      .en      (en),
      .act_s0  (in_ch.action),
      .act_s1  (act1_r),
      .act_s3  (act3_r),
      .tol     (tol_r),
      .a       (a_v[i]),
      .b       (b_v[i]),
      .s       (in_ch.scalar_in),
      .xa_j    (xa_j),
      .xb_k    (xb_k),
      .xa_k    (xa_k),
      .xb_j    (xb_j),
      .dot_s2  (dot2_r),
      .prod_s1 (prod_v[i]),
      .eq_s1   (eq_v[i]),
      .res_s4  (res_v[i]),
      .num_s4  (num_v[i]),
      .den_s4  (den_v[i])
    );
  end

  // merge of lane products: dot and sum of squares of x, y and z
  logic           pt1_r;
  logic [PW-1:0]  sq2_r, sq3_r, sq4_r;
  logic           flag2_r, flag3_r, flag4_r;
  logic           flag1;

  always_comb begin
    if (act1_r == ACT_EQ) flag1 = &eq_v;
    else if (act1_r == ACT_ISPOINT) flag1 = pt1_r;
    else flag1 = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      act1_r  <= in_ch.action;
      pt1_r   <= (in_ch.a_w != '0);
      act2_r  <= act1_r;
      dot2_r  <= sat_w((SW'(prod_v[0]) + SW'(prod_v[1]) + SW'(prod_v[2])
                        + SW'(prod_v[3])) >>> F);
      sq2_r   <= $unsigned(prod_v[0]) + $unsigned(prod_v[1]) + $unsigned(prod_v[2]);
      flag2_r <= flag1;
      act3_r  <= act2_r;
      dot3_r  <= dot2_r;
      sq3_r   <= sq2_r;
      flag3_r <= flag2_r;
      act4_r  <= act3_r;
      dot4_r  <= dot3_r;
      sq4_r   <= sq3_r;
      flag4_r <= flag3_r;
    end
  end

  // square root stage with side data alongside
  logic [W-1:0] root;
  side_t        side_in;
  side_t        side_r [SQ_ST];

  vga_sqrt #(
    .WORD_BITS (W)
  ) u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (sq4_r),
    .root (root)
  );

  always_comb begin
    side_in.act  = act4_r;
    side_in.dot  = dot4_r;
    side_in.flag = flag4_r;
    for (int i = 0; i < LANES; i++) begin
      side_in.res[i] = res_v[i];
      side_in.num[i] = num_v[i];
      side_in.den[i] = den_v[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_in;
      for (int k = 1; k < SQ_ST; k++) side_r[k] <= side_r[k-1];
    end
  end

  // divider lanes
  side_t               sd;
  logic [W-1:0]        mag;
  side2_t              side2_in;
  side2_t              side2_r [DV_ST];
  logic signed [W-1:0] q_v [LANES];
  logic [LANES-1:0]    dz_v;

  assign sd  = side_r[SQ_ST-1];
  assign mag = root[W-1] ? WMAX : root;

  for (genvar i = 0; i < LANES; i++) begin : g_div
    logic signed [W-1:0] dv_den;

    assign dv_den = (sd.act == ACT_NORM) ? mag : sd.den[i];

    vga_div #(
      .WORD_BITS (W),
      .FRAC_BITS (F)
    ) u_div (
      .clk (clk),
      .en  (en),
      .num (sd.num[i]),
      .den (dv_den),
      .quo (q_v[i]),
      .dz  (dz_v[i])
    );
  end

  always_comb begin
    side2_in.act  = sd.act;
    side2_in.flag = sd.flag;
    side2_in.res  = sd.res;
    if (sd.act == ACT_DOT) side2_in.sc = sd.dot;
    else if (sd.act == ACT_MAG || sd.act == ACT_NORM) side2_in.sc = mag;
    else side2_in.sc = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side2_r[0] <= side2_in;
      for (int k = 1; k < DV_ST; k++) side2_r[k] <= side2_r[k-1];
    end
  end

  // output register
  side2_t              s2;
  logic                is_div, is_norm;
  logic [W-1:0]        rf [LANES];
  logic                err_f;
  logic [W-1:0]        rx_o_r, ry_o_r, rz_o_r, rw_o_r, sc_o_r;
  logic                flag_o_r, err_o_r;
  logic [ACT_BITS-1:0] act_o_r;

  assign s2      = side2_r[DV_ST-1];
  assign is_div  = (s2.act == ACT_DIVS) || (s2.act == ACT_DIV);
  assign is_norm = (s2.act == ACT_NORM);

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      if (is_div) rf[i] = q_v[i];
      else if (is_norm) rf[i] = (i == LANES - 1) ? '0 : q_v[i];
      else rf[i] = s2.res[i];
    end
    // normalize divides x, y and z only
    if (is_div) err_f = |dz_v;
    else if (is_norm) err_f = |dz_v[2:0];
    else err_f = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx_o_r   <= rf[0];
      ry_o_r   <= rf[1];
      rz_o_r   <= rf[2];
      rw_o_r   <= rf[3];
      sc_o_r   <= s2.sc;
      flag_o_r <= s2.flag;
      err_o_r  <= err_f;
      act_o_r  <= s2.act;
    end
  end

  assign out_ch.r_x       = rx_o_r;
  assign out_ch.r_y       = ry_o_r;
  assign out_ch.r_z       = rz_o_r;
  assign out_ch.r_w       = rw_o_r;
  assign out_ch.r_scalar  = sc_o_r;
  assign out_ch.flag      = flag_o_r;
  assign out_ch.div_error = err_o_r;

  a_err_only_div: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[LAT-1] && err_o_r |->
      (act_o_r == ACT_DIVS || act_o_r == ACT_DIV || act_o_r == ACT_NORM))
    else $error("divide error on an action that does not divide");

  a_flag_only_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[LAT-1] && flag_o_r |-> (act_o_r == ACT_EQ || act_o_r == ACT_ISPOINT))
    else $error("flag set on an action without a flag");

  a_norm_w_zero: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[LAT-1] && act_o_r == ACT_NORM |-> rw_o_r == '0)
    else $error("normalize left w nonzero");

  a_xfer_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> vld_r[0])
    else $error("input transfer did not enter the pipeline");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline moved while stalled");
endmodule
`default_nettype wire
